FILE: sv/hecm_pkg.sv
// Package for the histogram-equalized colormap unit.
// Holds opcode codes, register indexes, widths, limits and the sequencer state type.
// No dependencies.
`default_nettype none
package hecm_pkg;

    localparam int unsigned CNT_W = 23;
    localparam int unsigned CYCLE = 1000;
    localparam int unsigned CYC_W = 10;
    localparam int unsigned MAX_PIXELS = 4194304;

    // 2^28/1000 rounded up: exact floor division by 1000 for products below 2^18
    localparam int unsigned FM_W = 28;
    localparam logic [FM_W-1:0] RECIP = 28'd268436;

    typedef enum logic [1:0] {
        FN_CLEAR = 2'd0,
        FN_COUNT = 2'd1,
        FN_FINAL = 2'd2,
        FN_COLOR = 2'd3
    } t_func;

    localparam logic [2:0] REG_MAX_ITER = 3'd0;
    localparam logic [2:0] REG_COLOR_CNT = 3'd1;
    localparam logic [2:0] REG_COLOR_0 = 3'd2;
    localparam logic [2:0] REG_COLOR_5 = 3'd7;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_RD,
        ST_WR,
        ST_CLR,
        ST_FIN_RD,
        ST_FIN_WR,
        ST_DIV,
        ST_SEG,
        ST_MUL,
        ST_BLEND,
        ST_OUT
    } t_state;

    // Blend one channel: lo + floor((hi-lo)*frac/1000), truncating toward negative.
    // fm is frac times RECIP; the shift by FM_W finishes the division by 1000.
    function automatic logic [7:0] blend_chan(input logic [7:0] lo, input logic [7:0] hi,
                                              input logic [FM_W-1:0] fm);
        logic [36:0] prod;
        if (hi >= lo) begin
            prod = 37'(hi - lo) * 37'(fm);
            return lo + 8'(prod >> FM_W);
        end else begin
            prod = 37'(lo - hi) * 37'(fm) + 37'(RECIP) * 37'(CYCLE - 1);
            return lo - 8'(prod >> FM_W);
        end
    endfunction

endpackage
`default_nettype wire

FILE: sv/histogram_equalized_colormap_unit.sv
// Top level of the histogram-equalized colormap unit.
// Depends on hecm_pkg, hecm_bin_ram and hecm_divider.
//
// Usage: items arrive on the s_axis channel. tdata bits [1:0] func, [2] in_set,
// [18:3] iter_count. Clear, count and finalize transfers give no result; color
// gives one transfer on m_axis: tdata [7:0] red, [15:8] green, [23:16] blue,
// [24] no_pixels. Configuration writes land on the i_cfg port between items.
// Rate: one item at a time. A count reads and writes back one bin before the
// next transfer is taken. Clear sweeps the bin memory and finalize rewrites it
// as a running sum, each before the next transfer is taken. Color divides
// 1000*cum by the pixel total in a 33-step divider and registers the blended
// result; in-set or empty pixels skip the divider. The next item can be taken
// in the cycle after the result leaves.
// Reset: a clearing pass over all HIST_BINS bins zeroes the bin memory; no item is
// taken meanwhile, configuration writes are. Registers return to defaults.
// Stall: the result holds in the output register until taken; the next item is
// taken only once the result has left.
`default_nettype none
module histogram_equalized_colormap_unit
    import hecm_pkg::*;
#(
    parameter int unsigned HIST_BINS = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // func, in_set, iter_count
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // red, green, blue, no_pixels
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [23:0] i_cfg_wdata
);
    localparam int unsigned AW = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;
    localparam int unsigned NUM_W = CNT_W + CYC_W;

    // configuration registers
    logic [9:0]  r_max_iter;
    logic [2:0]  r_color_cnt;
    logic [23:0] r_pal [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter  <= 10'd1023;
            r_color_cnt <= 3'd2;
            for (int k = 0; k < 6; k++) begin
                r_pal[k] <= (k == 1) ? 24'hFFFFFF : 24'h0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_addr == REG_MAX_ITER) begin
                r_max_iter <= i_cfg_wdata[9:0];
            end else if (i_cfg_addr == REG_COLOR_CNT) begin
                r_color_cnt <= i_cfg_wdata[2:0];
            end else if (i_cfg_addr >= REG_COLOR_0 && i_cfg_addr <= REG_COLOR_5) begin
                r_pal[3'(i_cfg_addr - REG_COLOR_0)] <= i_cfg_wdata;
            end
        end
    end

    // item fields
    logic [1:0]  w_func;
    logic        w_set;
    logic [15:0] w_iter;
    assign w_func = s_axis_tdata[1:0];
    assign w_set  = s_axis_tdata[2];
    assign w_iter = s_axis_tdata[18:3];

    // bin pick: in-set goes to max_iter, others clamp, then clamp to memory depth
    logic [15:0] w_b0;
    logic [AW-1:0] w_bin;
    always_comb begin
        w_b0 = (w_set || w_iter > 16'(r_max_iter)) ? 16'(r_max_iter) : w_iter;
        if (32'(w_b0) > HIST_BINS - 1) begin
            w_bin = AW'(HIST_BINS - 1);
        end else begin
            w_bin = AW'(w_b0);
        end
    end

    t_state r_state, n_state;
    logic [AW:0]       r_idx;
    logic [AW-1:0]     r_addr;
    logic              r_set;
    logic [1:0]        r_func;
    logic [CNT_W-1:0]  r_total;
    logic [CNT_W:0]    r_run;
    logic [CNT_W-1:0]  w_rdata;
    logic              w_we;
    logic [AW-1:0]     w_waddr, w_raddr;
    logic [CNT_W-1:0]  w_wdata;
    logic              w_div_start, w_div_done;
    logic [CYC_W-1:0]  w_qmod;
    logic [CYC_W-1:0]  r_v;
    logic [12:0]       r_scaled;
    logic [2:0]        r_seg;
    logic [FM_W-1:0]   r_fm;
    logic [2:0]        w_seg_q;
    logic [12:0]       w_frac_s;
    logic [23:0]       w_lc, w_rc;
    logic [2:0]        w_n;
    logic              r_out_valid;
    logic [24:0]       r_out;

    hecm_bin_ram #(.DEPTH(HIST_BINS), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    hecm_divider #(.NUM_W(NUM_W), .DEN_W(CNT_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (NUM_W'(w_rdata) * NUM_W'(CYCLE)),
        .i_den   (r_total),
        .o_done  (w_div_done),
        .o_qmod  (w_qmod)
    );

    assign w_n = (r_color_cnt < 3'd2) ? 3'd2 : ((r_color_cnt > 3'd6) ? 3'd6 : r_color_cnt);
    assign s_axis_tready = (r_state == ST_IDLE) && !r_out_valid;

    always_comb begin
        n_state     = r_state;
        w_we        = 1'b0;
        w_waddr     = r_addr;
        w_wdata     = '0;
        w_raddr     = w_bin;
        w_div_start = 1'b0;
        unique case (r_state)
            ST_INIT, ST_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_idx[AW-1:0];
                if (r_idx == (AW+1)'(HIST_BINS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    unique case (t_func'(w_func))
                        FN_CLEAR: n_state = ST_CLR;
                        FN_COUNT: n_state = (r_total < CNT_W'(MAX_PIXELS)) ? ST_RD : ST_IDLE;
                        FN_FINAL: n_state = ST_FIN_RD;
                        FN_COLOR: n_state = ST_RD;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RD: begin
                // read data valid this cycle
                if (r_func == FN_COUNT) begin
                    w_we    = 1'b1;
                    w_wdata = w_rdata + 1'b1;
                    n_state = ST_IDLE;
                end else if (r_set || r_total == '0) begin
                    n_state = ST_OUT;
                end else begin
                    w_div_start = 1'b1;
                    n_state = ST_DIV;
                end
            end
            ST_FIN_RD: begin
                w_raddr = r_idx[AW-1:0];
                n_state = ST_FIN_WR;
            end
            ST_FIN_WR: begin
                w_we    = 1'b1;
                w_waddr = r_idx[AW-1:0];
                w_wdata = r_run[CNT_W-1:0];
                w_raddr = AW'(r_idx + 1'b1);
                if (r_idx == (AW+1)'(HIST_BINS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIV:   if (w_div_done) n_state = ST_SEG;
            ST_SEG:   n_state = ST_MUL;
            ST_MUL:   n_state = ST_BLEND;
            ST_BLEND: n_state = ST_OUT;
            ST_OUT:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // split the scaled position into palette segment and fraction by compare and subtract
    always_comb begin
        w_seg_q  = 3'd0;
        w_frac_s = r_scaled;
        for (int k = 4; k >= 1; k--) begin
            if (w_seg_q == 3'd0 && r_scaled >= 13'(k * CYCLE)) begin
                w_seg_q  = 3'(k);
                w_frac_s = r_scaled - 13'(k * CYCLE);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_idx       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_INIT, ST_CLR: r_idx <= r_idx + 1'b1;
                ST_IDLE: begin
                    r_idx  <= '0;
                    r_run  <= '0;
                    r_addr <= w_bin;
                    r_set  <= w_set;
                    r_func <= w_func;
                    if (s_axis_tvalid && s_axis_tready) begin
                        if (t_func'(w_func) == FN_CLEAR) begin
                            r_total <= '0;
                        end else if (t_func'(w_func) == FN_COUNT &&
                                     r_total < CNT_W'(MAX_PIXELS)) begin
                            r_total <= r_total + 1'b1;
                        end
                    end
                end
                ST_FIN_WR: begin
                    r_idx <= r_idx + 1'b1;
                    // saturating running sum
                    if ((r_run + (CNT_W+1)'(w_rdata)) > (CNT_W+1)'(MAX_PIXELS)) begin
                        r_run <= (CNT_W+1)'(MAX_PIXELS);
                    end else begin
                        r_run <= r_run + (CNT_W+1)'(w_rdata);
                    end
                end
                ST_SEG: begin
                    // divider hands over the quotient already reduced mod 1000
                    r_v <= w_qmod;
                end
                ST_MUL: begin
                    r_scaled <= 13'(r_v) * 13'(w_n - 3'd1);
                end
                ST_BLEND: begin
                    r_seg <= w_seg_q;
                    r_fm  <= FM_W'(w_frac_s) * RECIP;
                end
                ST_OUT: begin
                    r_out_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // palette pick and output
    logic [2:0] w_seg;
    assign w_seg = (r_seg > w_n - 3'd2) ? w_n - 3'd2 : r_seg;
    always_comb begin
        w_lc = r_pal[w_seg];
        w_rc = r_pal[3'(w_seg + 3'd1)];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT) begin
            if (r_total == '0 || r_set) begin
                r_out <= {r_total == '0, 24'h0};
            end else begin
                r_out <= {1'b0,
                          blend_chan(w_lc[7:0], w_rc[7:0], r_fm),
                          blend_chan(w_lc[15:8], w_rc[15:8], r_fm),
                          blend_chan(w_lc[23:16], w_rc[23:16], r_fm)};
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out};

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready)
        else $error("item taken while busy");
    a_total_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CNT_W'(MAX_PIXELS))
        else $error("pixel total past cap");
endmodule
`default_nettype wire

FILE: sv/hecm_divider.sv
// Restoring divider: quotient of a numerator by the pixel total, one bit a cycle,
// delivered reduced modulo the palette cycle. Depends on hecm_pkg.
`default_nettype none
module hecm_divider
    import hecm_pkg::*;
#(
    parameter int unsigned NUM_W = 33,
    parameter int unsigned DEN_W = 23
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [CYC_W-1:0]      o_qmod
);
    localparam int unsigned CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic [CYC_W-1:0] r_qmod;
    logic [DEN_W:0]   w_trial;
    logic             w_bit;
    logic [CYC_W:0]   w_qm2;

    assign w_trial = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
    assign w_bit   = (w_trial >= {1'b0, r_den});
    // reduced quotient doubled plus the new bit; below 2000 since r_qmod stays below 1000
    assign w_qm2   = {r_qmod, w_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_qmod <= '0;
            end else if (r_busy) begin
                if (w_bit) begin
                    r_rem <= w_trial - {1'b0, r_den};
                    r_num <= {r_num[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_num <= {r_num[NUM_W-2:0], 1'b0};
                end
                if (w_qm2 >= (CYC_W+1)'(CYCLE)) begin
                    r_qmod <= CYC_W'(w_qm2 - (CYC_W+1)'(CYCLE));
                end else begin
                    r_qmod <= w_qm2[CYC_W-1:0];
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_qmod = r_qmod;
endmodule
`default_nettype wire

FILE: sv/hecm_bin_ram.sv
// Histogram bin memory: one write port, one registered read port.
// Depends on hecm_pkg.
`default_nettype none
module hecm_bin_ram
    import hecm_pkg::*;
#(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [CNT_W-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic [CNT_W-1:0]      o_rdata
);
    logic [CNT_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: verif/tb_histogram_equalized_colormap_unit.sv
// Self-checking testbench for histogram_equalized_colormap_unit.
// Depends on hecm_pkg and the unit's RTL; predicts each color result from its own
// copy of the histogram, the pixel total and the palette registers.
`default_nettype none
module tb_histogram_equalized_colormap_unit
    import hecm_pkg::*;
();

    localparam int unsigned NBINS = 1024;
    localparam int unsigned PIX_CAP = 4194304;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       no_pixels;
    } t_color;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // func, in_set, iter_count
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // red, green, blue, no_pixels
    logic        i_cfg_we;
    logic [2:0]  i_cfg_addr;
    logic [23:0] i_cfg_wdata;

    histogram_equalized_colormap_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow state of the unit.
    logic [22:0] hist_sum[NBINS];
    logic [22:0] pix_total;
    logic [9:0]  lim_iter;
    logic [2:0]  pal_size;
    logic [23:0] palette[6];

    t_color color_q[$];
    int     n_fail;
    int     n_items;
    int     n_colors;
    bit     calm;       // suppress random idling on both sides

    function automatic logic [9:0] bin_of(input logic in_set, input logic [15:0] iters);
        logic [15:0] b;
        b = in_set ? 16'(lim_iter) : (iters > 16'(lim_iter) ? 16'(lim_iter) : iters);
        if (b > 16'(NBINS - 1)) b = 16'(NBINS - 1);
        return b[9:0];
    endfunction

    function automatic logic [7:0] mix_chan(input logic [7:0] lo, input logic [7:0] hi,
                                            input int unsigned frac);
        int unsigned d;
        if (hi >= lo) return lo + 8'((int'(hi - lo) * frac) / 1000);
        d = (int'(lo - hi) * frac + 999) / 1000;
        return lo - 8'(d);
    endfunction

    // Apply one item to the shadow state; queue the color it yields, if any.
    task automatic predict_item(input t_func fn, input logic in_set, input logic [15:0] iters);
        longint unsigned run, here, cum, v, scaled, seg, frac, n;
        logic [23:0] lc, rc;
        t_color c;
        case (fn)
            FN_CLEAR: begin
                foreach (hist_sum[i]) hist_sum[i] = '0;
                pix_total = '0;
            end
            FN_COUNT: begin
                if (pix_total < PIX_CAP) begin
                    hist_sum[bin_of(in_set, iters)]++;
                    pix_total++;
                end
            end
            FN_FINAL: begin
                run = 0;
                foreach (hist_sum[i]) begin
                    here = hist_sum[i];
                    hist_sum[i] = 23'(run);
                    run += here;
                    if (run > PIX_CAP) run = PIX_CAP;
                end
            end
            default: begin
                c = '0;
                c.no_pixels = (pix_total == 0);
                if (!c.no_pixels && !in_set) begin
                    n = pal_size < 2 ? 2 : (pal_size > 6 ? 6 : pal_size);
                    cum = hist_sum[bin_of(1'b0, iters)];
                    v = (1000 * cum / pix_total) % 1000;
                    scaled = v * (n - 1);
                    seg = scaled / 1000;
                    frac = scaled % 1000;
                    if (seg > n - 2) seg = n - 2;
                    lc = palette[seg];
                    rc = palette[seg + 1];
                    c.red = mix_chan(lc[23:16], rc[23:16], frac);
                    c.green = mix_chan(lc[15:8], rc[15:8], frac);
                    c.blue = mix_chan(lc[7:0], rc[7:0], frac);
                end
                color_q.push_back(c);
            end
        endcase
    endtask

    // Send one item; hold tvalid until the transfer. tvalid stays high afterward
    // so that the next item can follow at once; drain drops it.
    task automatic send_item(input t_func fn, input logic in_set, input logic [15:0] iters);
        while (!calm && $urandom_range(99) < 6) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, iters, in_set, fn};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_item(fn, in_set, iters);
        n_items++;
    endtask

    // Drop tvalid, wait for every result, let a finalize sweep finish.
    task automatic drain;
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (color_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (2 * NBINS + 50) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_MAX_ITER:  lim_iter = val[9:0];
            REG_COLOR_CNT: pal_size = val[2:0];
            default:       palette[idx - REG_COLOR_0] = val;
        endcase
    endtask

    task automatic random_palette(input logic [2:0] size);
        drain();
        write_reg(REG_COLOR_CNT, 24'(size));
        for (int i = 0; i < 6; i++) write_reg(3'(REG_COLOR_0 + i), 24'($urandom));
    endtask

    function automatic logic [15:0] rand_iter;
        case ($urandom_range(5))
            0: return 16'($urandom);
            1: return 16'(lim_iter) + 16'($urandom_range(3));
            default: return 16'($urandom_range(lim_iter));
        endcase
    endfunction

    // Directed: extremes of fields, every opcode, zero-pixel and in-set cases.
    task automatic test_directed;
        send_item(FN_COLOR, 1'b0, 16'd5);          // empty histogram
        send_item(FN_COLOR, 1'b1, 16'd0);          // empty, in-set
        send_item(FN_COUNT, 1'b0, 16'd0);
        send_item(FN_COUNT, 1'b0, 16'hFFFF);       // clamped to max_iter
        send_item(FN_COUNT, 1'b1, 16'h5555);
        send_item(FN_COUNT, 1'b0, 16'hAAAA);
        send_item(FN_COUNT, 1'b0, 16'd7);
        send_item(FN_COLOR, 1'b0, 16'd7);          // before finalize
        send_item(FN_FINAL, 1'b0, 16'd0);
        send_item(FN_COLOR, 1'b0, 16'd0);
        send_item(FN_COLOR, 1'b0, 16'd7);
        send_item(FN_COLOR, 1'b0, 16'hFFFF);
        send_item(FN_COLOR, 1'b1, 16'd3);          // in-set gives black
        send_item(FN_FINAL, 1'b1, 16'hFFFF);       // repeated finalize
        send_item(FN_COLOR, 1'b0, 16'd1023);
        send_item(FN_CLEAR, 1'b1, 16'hFFFF);
        send_item(FN_COLOR, 1'b0, 16'd1);
    endtask

    // One frame: clear, count a handful of pixels, usually finalize, color some.
    task automatic run_frame(input int n_count, input int n_color);
        send_item(FN_CLEAR, 1'($urandom), 16'($urandom));
        for (int i = 0; i < n_count; i++) send_item(FN_COUNT, $urandom_range(7) == 0, rand_iter());
        if ($urandom_range(9) != 0) send_item(FN_FINAL, 1'($urandom), 16'($urandom));
        for (int i = 0; i < n_color; i++) send_item(FN_COLOR, $urandom_range(9) == 0, rand_iter());
    endtask

    task automatic test_settings;
        logic [9:0] lims[4];
        lims = '{10'd1, 10'd1023, 10'd0, 10'd12};
        foreach (lims[k]) begin
            drain();
            write_reg(REG_MAX_ITER, 24'(lims[k]));
            random_palette(3'(k == 2 ? 0 : (k == 3 ? 7 : 6 - k)));
            run_frame(12, 10);
            run_frame(3, 6);
        end
    endtask

    task automatic test_random;
        while (n_items < 1850) begin
            if ($urandom_range(7) == 0) begin
                drain();
                write_reg(REG_MAX_ITER, 24'($urandom_range(1, 1023) >> $urandom_range(6)));
                random_palette(3'($urandom_range(2, 6)));
            end
            calm = (n_items > 900 && n_items < 1100);
            if ($urandom_range(9) == 0)
                send_item(t_func'($urandom_range(3)), 1'($urandom), 16'($urandom));
            else
                run_frame($urandom_range(1, 30), $urandom_range(1, 20));
        end
        calm = 1'b0;
    endtask

    // Compare each color transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_color got, want;
        if (i_rst_n) begin
            m_axis_tready <= calm || ($urandom_range(99) >= 6);
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                       m_axis_tdata[24]};
                if (color_q.size() == 0) begin
                    $error("color transfer with none expected: %h", m_axis_tdata);
                    n_fail++;
                end else begin
                    want = color_q.pop_front();
                    n_colors++;
                    if (got.red !== want.red) begin
                        $error("red: expected %0d, got %0d", want.red, got.red); n_fail++;
                    end
                    if (got.green !== want.green) begin
                        $error("green: expected %0d, got %0d", want.green, got.green); n_fail++;
                    end
                    if (got.blue !== want.blue) begin
                        $error("blue: expected %0d, got %0d", want.blue, got.blue); n_fail++;
                    end
                    if (got.no_pixels !== want.no_pixels) begin
                        $error("no_pixels: expected %0d, got %0d", want.no_pixels,
                               got.no_pixels);
                        n_fail++;
                    end
                end
            end
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        n_fail = 0; n_items = 0; n_colors = 0; calm = 1'b0;
        foreach (hist_sum[i]) hist_sum[i] = '0;
        pix_total = '0;
        lim_iter = 10'd1023;
        pal_size = 3'd2;
        foreach (palette[i]) palette[i] = '0;
        palette[1] = 24'hFFFFFF;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_settings();
        test_random();
        drain();
        $display("Covered %0d items, %0d color transfers checked, across clamp limits",
                 n_items, n_colors);
        $display("and palette sizes from below 2 to above 6.");
        if (n_fail == 0 && color_q.size() == 0) begin
            $display("PASS histogram_equalized_colormap_unit");
        end else begin
            $display("FAIL histogram_equalized_colormap_unit");
        end
        $finish;
    end

    // Limit: generous bound on sweeps, divides and stalls.
    initial begin
        #40000000;
        $display("FAIL histogram_equalized_colormap_unit");
        $finish;
    end

endmodule
`default_nettype wire
